>>> sv/ntn_pkg.sv
// Shared types and constants for the normal transform and normalise block.
package ntn_pkg;

    localparam int COMP_W       = 16;
    localparam int COEF_W       = 16;
    localparam int ROW_W        = 3 * COEF_W;
    localparam int ROOT_ITERS   = 3;
    localparam int OUT_SHIFT    = 62 - COMP_W;

    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] Q30_THREE = 64'd3 << 30;
    localparam logic [63:0] RND_HALF  = 64'd1 << (OUT_SHIFT - 1);
    localparam logic [16:0] UNIT_OUT  = 17'd1 << (COMP_W - 2);

    localparam logic [31:0] R0_LT_HALF = 32'd1717986918;
    localparam logic [31:0] R0_LT_ONE  = 32'd1288490189;
    localparam logic [31:0] R0_LT_TWO  = 32'd912680550;
    localparam logic [31:0] R0_OTHER   = 32'd697932186;

    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;

    typedef struct packed {
        logic              vld;
        logic              zero;
        logic [2:0]        neg;
        logic [2:0][32:0]  u;
        logic [5:0]        msb;
        logic [31:0]       t;
        logic [31:0]       r;
        logic [63:0]       w;
        logic [2:0][63:0]  sq;
    } pl_t;

endpackage

>>> sv/ntn_newton.sv
// One Newton reciprocal square root iteration, three register stages.
module ntn_newton
    import ntn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  pl_t  din,
    output pl_t  dout
);

    pl_t a_reg, a_next;
    pl_t b_reg, b_next;
    pl_t c_reg, c_next;

    logic [63:0] rr;
    logic [63:0] tq;
    logic [63:0] p;
    logic [63:0] rd;

    always_comb
    begin
        rr = {32'd0, din.r} * {32'd0, din.r};
        a_next = din;
        a_next.w = rr >> 30;

        // r*r >> 30 stays below 2^34
        tq = {32'd0, a_reg.t} * {30'd0, a_reg.w[33:0]};
        p = tq >> 30;
        if (p > Q30_THREE)
        begin
            p = Q30_THREE;
        end
        b_next = a_reg;
        b_next.w = Q30_THREE - p;

        // 3.0 - p stays below 2^32
        rd = {32'd0, b_reg.r} * {32'd0, b_reg.w[31:0]};
        c_next = b_reg;
        c_next.r = rd[62:31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign dout = c_reg;

endmodule

>>> sv/normal_transform_normalize.sv
// Top level: 3x3 normal transform followed by unit-length normalisation.
// Accepts one word per cycle while the output is not stalled and returns one
// word per input. Products, row sums, leading-one search, normalising shift,
// squares, square sum with seed, ROOT_ITERS Newton iterations, scaling products
// and output are each registered in turn. A stalled output freezes the whole pipe.
// Matrix rows sit at APB byte addresses 0x00, 0x08, 0x10 (48 bits in 64).
module normal_transform_normalize
    import ntn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [63:0]              pwdata,
    output logic [63:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [COMP_W-1:0] in_x,
    input  logic signed [COMP_W-1:0] in_y,
    input  logic signed [COMP_W-1:0] in_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [COMP_W-1:0] out_x,
    output logic signed [COMP_W-1:0] out_y,
    output logic signed [COMP_W-1:0] out_z,
    output logic                     zero_length
);

    logic [ROW_W-1:0] row_reg [3];
    logic             wr_en;
    logic [1:0]       wr_idx;
    logic             adv;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_W'(64'd1 << (COEF_W - 4 + 2 * COEF_W));
            row_reg[1] <= ROW_W'(64'd1 << (COEF_W - 4 + COEF_W));
            row_reg[2] <= ROW_W'(64'd1 << (COEF_W - 4));
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_ROW0: row_reg[0] <= pwdata[ROW_W-1:0];
                REG_ROW1: row_reg[1] <= pwdata[ROW_W-1:0];
                REG_ROW2: row_reg[2] <= pwdata[ROW_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_ROW0: prdata = 64'(row_reg[0]);
            REG_ROW1: prdata = 64'(row_reg[1]);
            REG_ROW2: prdata = 64'(row_reg[2]);
            default:  prdata = '0;
        endcase
    end

    // pipeline
    logic                     out_vld_reg;
    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    logic                     s1_vld_reg;
    logic signed [31:0]       prod_reg [3][3];
    logic signed [COMP_W-1:0] vin [3];
    pl_t s2_reg, s2_next;
    pl_t s3_reg, s3_next;
    pl_t s4_reg, s4_next;
    pl_t s5_reg, s5_next;
    pl_t s6_reg, s6_next;
    pl_t f1_reg, f1_next;
    pl_t nchain [ROOT_ITERS+1];

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= 32'($signed(row_reg[i][(2-j)*COEF_W +: COEF_W])
                                          * vin[j]);
                end
            end
        end
    end

    logic signed [33:0] acc [3];
    logic [32:0]        mx;
    logic [63:0]        tt;

    always_comb
    begin
        s2_next = '0;
        s2_next.vld = s1_vld_reg;
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 34'(prod_reg[i][0]) + 34'(prod_reg[i][1]) + 34'(prod_reg[i][2]);
            s2_next.neg[i] = acc[i][33];
            s2_next.u[i] = acc[i][33] ? 33'(-acc[i]) : 33'(acc[i]);
        end
        s2_next.zero = (acc[0] == '0) && (acc[1] == '0) && (acc[2] == '0);

        // leading one of the largest magnitude
        s3_next = s2_reg;
        mx = s2_reg.u[0];
        if (s2_reg.u[1] > mx) mx = s2_reg.u[1];
        if (s2_reg.u[2] > mx) mx = s2_reg.u[2];
        s3_next.msb = '0;
        for (int b = 0; b < 33; b++)
        begin
            if (mx[b]) s3_next.msb = 6'(b);
        end

        s4_next = s3_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (s3_reg.msb > 6'd29)
                s4_next.u[i] = s3_reg.u[i] >> (s3_reg.msb - 6'd29);
            else
                s4_next.u[i] = s3_reg.u[i] << (6'd29 - s3_reg.msb);
        end

        s5_next = s4_reg;
        for (int i = 0; i < 3; i++)
        begin
            s5_next.sq[i] = 64'(s4_reg.u[i][29:0]) * 64'(s4_reg.u[i][29:0]);
        end

        s6_next = s5_reg;
        tt = (s5_reg.sq[0] + s5_reg.sq[1] + s5_reg.sq[2]) >> 30;
        s6_next.t = tt[31:0];
        priority if (tt < (Q30_ONE >> 1)) s6_next.r = R0_LT_HALF;
        else if (tt < Q30_ONE)            s6_next.r = R0_LT_ONE;
        else if (tt < (Q30_ONE << 1))     s6_next.r = R0_LT_TWO;
        else                              s6_next.r = R0_OTHER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    assign nchain[0] = s6_reg;

    for (genvar k = 0; k < ROOT_ITERS; k++)
    begin : g_iter
        ntn_newton u_newton
        (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (nchain[k]),
            .dout  (nchain[k+1])
        );
    end

    logic [63:0]       rnd [3];
    logic [16:0]       mag [3];
    logic [COMP_W-1:0] res [3];
    logic [COMP_W-1:0] ox_reg, oy_reg, oz_reg;
    logic              oz_len_reg;

    always_comb
    begin
        f1_next = nchain[ROOT_ITERS];
        for (int i = 0; i < 3; i++)
        begin
            f1_next.sq[i] = 64'(nchain[ROOT_ITERS].u[i][29:0]) * 64'(nchain[ROOT_ITERS].r);
        end

        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (f1_reg.sq[i] + RND_HALF) >> OUT_SHIFT;
            mag[i] = (rnd[i] > 64'(UNIT_OUT)) ? UNIT_OUT : rnd[i][16:0];
            if (f1_reg.zero)
                res[i] = '0;
            else if (f1_reg.neg[i])
                res[i] = COMP_W'(-mag[i]);
            else
                res[i] = COMP_W'(mag[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_reg      <= f1_next;
            out_vld_reg <= f1_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg     <= res[0];
            oy_reg     <= res[1];
            oz_reg     <= res[2];
            oz_len_reg <= f1_reg.zero;
        end
    end

    assign out_valid   = out_vld_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_z       = oz_reg;
    assign zero_length = oz_len_reg;

`ifndef SYNTHESIS
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("zero length word with nonzero components");
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_x <= 16'sd16384 && out_x >= -16'sd16384
                   && out_y <= 16'sd16384 && out_y >= -16'sd16384
                   && out_z <= 16'sd16384 && out_z >= -16'sd16384)
        else $error("component beyond unit");
    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input held off without output stall");
`endif

endmodule
